// ===== rtl/core/icdb_pkg.sv =====
// shared types and constants for the indexed byte deque
package icdb_pkg;

  // field widths
  localparam int CMD_W  = 3;
  localparam int IDX_W  = 6;
  localparam int CHAR_W = 8;
  localparam int LEN_W  = 7;
  localparam int ST_W   = 2;

  // capacity register value after reset
  localparam logic [LEN_W-1:0] CAP_RESET = 7'd64;

  // command codes
  localparam logic [CMD_W-1:0] CMD_INSERT     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ERASE      = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd5;

  // result status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [ST_W-1:0] ST_INDEX = 2'd3;

  // controller to datapath commands
  typedef struct packed {
    logic load;   // capture the incoming command
    logic exec;   // apply the captured command and load the result
  } ctl_t;

endpackage

// ===== rtl/core/icdb_ctrl.sv =====
// controller state machine: input capture, execute step, result valid
module icdb_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  output icdb_pkg::ctl_t  ctl
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // handshake and command decode
  assign in_stall  = (state_r == S_EXEC);
  assign out_valid = out_valid_r;
  assign ctl.load  = in_valid && (state_r == S_IDLE);
  assign ctl.exec  = (state_r == S_EXEC) && (!out_valid_r || !out_stall);

  // next state and result valid
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (ctl.load) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (ctl.exec) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // a captured command is always followed by its execute step
  a_load_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load |=> (state_r == S_EXEC))
    else $error("captured command did not enter execute");

  // execute never overwrites a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && out_valid_r && out_stall) |=> (state_r == S_EXEC))
    else $error("command left execute while result was stalled");

  // execute publishes a result and frees the input side
  a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.exec |=> (out_valid_r && state_r == S_IDLE))
    else $error("execute step did not produce a result");

  // capture and execute never happen together
  a_load_exec_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.load && ctl.exec))
    else $error("capture and execute in the same cycle");

endmodule

// ===== rtl/core/icdb_dpath.sv =====
// datapath: shifting byte cells, length and capacity registers, result registers
module icdb_dpath #(
  parameter int DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  icdb_pkg::ctl_t                ctl,
  input  logic [icdb_pkg::CMD_W-1:0]    in_cmd,
  input  logic [icdb_pkg::IDX_W-1:0]    in_char_index,
  input  logic [icdb_pkg::CHAR_W-1:0]   in_char_in,
  input  logic                          cfg_we,
  input  logic [icdb_pkg::LEN_W-1:0]    cfg_capacity,
  output logic [icdb_pkg::CHAR_W-1:0]   out_char_out,
  output logic [icdb_pkg::LEN_W-1:0]    out_length_now,
  output logic [icdb_pkg::ST_W-1:0]     out_status
);

  localparam int LEN_W  = icdb_pkg::LEN_W;
  localparam int CHAR_W = icdb_pkg::CHAR_W;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DW     = $clog2(DEPTH + 1);
  localparam int CMP_W  = (DW > LEN_W) ? DW : LEN_W;

  // byte cells
  logic [CHAR_W-1:0] slot_r   [DEPTH];
  logic [CHAR_W-1:0] slot_nxt [DEPTH];

  // captured command
  logic [icdb_pkg::CMD_W-1:0] cmd_r;
  logic [icdb_pkg::IDX_W-1:0] idx_r;
  logic [CHAR_W-1:0]          char_r;
  logic [CHAR_W-1:0]          tail_r;

  // control state
  logic [LEN_W-1:0] len_r;
  logic [LEN_W-1:0] cap_r;

  // result registers
  logic [CHAR_W-1:0]         char_out_r;
  logic [LEN_W-1:0]          len_out_r;
  logic [icdb_pkg::ST_W-1:0] status_r;

  // execute-step decode
  logic [CHAR_W-1:0]         char_nxt;
  logic [LEN_W-1:0]          len_nxt;
  logic [icdb_pkg::ST_W-1:0] status_nxt;
  logic                      do_ins;
  logic                      do_del;
  logic [LEN_W-1:0]          pos;
  logic [LEN_W-1:0]          idx_ext;
  logic [CMP_W-1:0]          cap_eff;
  logic [CMP_W-1:0]          pos_w;
  logic [CMP_W-1:0]          tail_pos;
  logic                      full;
  logic                      empty;

  assign idx_ext  = {1'b0, idx_r};
  assign cap_eff  = (CMP_W'(cap_r) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(cap_r);
  assign full     = (CMP_W'(len_r) >= cap_eff);
  assign empty    = (len_r == '0);
  assign pos_w    = CMP_W'(pos);
  assign tail_pos = CMP_W'(len_r) - CMP_W'(1);

  // command checks and cell operation select
  always_comb begin
    status_nxt = icdb_pkg::ST_OK;
    char_nxt   = '0;
    len_nxt    = len_r;
    do_ins     = 1'b0;
    do_del     = 1'b0;
    pos        = idx_ext;
    unique case (cmd_r)
      icdb_pkg::CMD_INSERT: begin
        if (full) begin
          status_nxt = icdb_pkg::ST_FULL;
        end else if (idx_ext > len_r) begin
          status_nxt = icdb_pkg::ST_INDEX;
        end else begin
          do_ins  = 1'b1;
          len_nxt = len_r + LEN_W'(1);
        end
      end
      icdb_pkg::CMD_ERASE: begin
        if (idx_ext >= len_r) begin
          status_nxt = icdb_pkg::ST_INDEX;
        end else begin
          do_del  = 1'b1;
          len_nxt = len_r - LEN_W'(1);
        end
      end
      icdb_pkg::CMD_PUSH_FRONT: begin
        pos = '0;
        if (full) begin
          status_nxt = icdb_pkg::ST_FULL;
        end else begin
          do_ins  = 1'b1;
          len_nxt = len_r + LEN_W'(1);
        end
      end
      icdb_pkg::CMD_POP_FRONT: begin
        pos = '0;
        if (empty) begin
          status_nxt = icdb_pkg::ST_EMPTY;
        end else begin
          do_del   = 1'b1;
          char_nxt = slot_r[0];
          len_nxt  = len_r - LEN_W'(1);
        end
      end
      icdb_pkg::CMD_PUSH_BACK: begin
        pos = len_r;
        if (full) begin
          status_nxt = icdb_pkg::ST_FULL;
        end else begin
          do_ins  = 1'b1;
          len_nxt = len_r + LEN_W'(1);
        end
      end
      icdb_pkg::CMD_POP_BACK: begin
        if (empty) begin
          status_nxt = icdb_pkg::ST_EMPTY;
        end else begin
          char_nxt = tail_r;
          len_nxt  = len_r - LEN_W'(1);
        end
      end
      default: begin
        status_nxt = icdb_pkg::ST_OK;
      end
    endcase
  end

  // per-cell next value: hold, take the new byte, or shift from a neighbor
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    localparam logic [CMP_W-1:0] POS_C = CMP_W'(g);
    logic [CHAR_W-1:0] left;
    logic [CHAR_W-1:0] right;
    if (g == 0) begin : g_first
      assign left = char_r;
    end else begin : g_mid_l
      assign left = slot_r[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = slot_r[g+1];
    end
    assign slot_nxt[g] = (do_ins && pos_w == POS_C) ? char_r :
                         (do_ins && pos_w <  POS_C) ? left   :
                         (do_del && pos_w <= POS_C) ? right  : slot_r[g];
  end

  // byte cells, captured command and result registers (no reset)
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r  <= in_cmd;
      idx_r  <= in_char_index;
      char_r <= in_char_in;
      tail_r <= slot_r[tail_pos[AW-1:0]];
    end
    if (ctl.exec) begin
      slot_r     <= slot_nxt;
      char_out_r <= char_nxt;
      len_out_r  <= len_nxt;
      status_r   <= status_nxt;
    end
  end

  // length and capacity
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      cap_r <= icdb_pkg::CAP_RESET;
    end else begin
      if (ctl.exec) begin
        len_r <= len_nxt;
      end
      if (cfg_we) begin
        cap_r <= cfg_capacity;
      end
    end
  end

  assign out_char_out   = char_out_r;
  assign out_length_now = len_out_r;
  assign out_status     = status_r;

endmodule

// ===== rtl/core/indexed_char_deque_buffer_core.sv =====
// Indexed byte deque: gap-free byte buffer with insert/erase at an index and
// push/pop at both ends.
// Input channel (in_valid / in_stall): one command per transfer, with in_cmd,
// in_char_index and in_char_in. Result channel (out_valid / out_stall): one
// result per command, with the popped byte (zero unless a pop succeeded), the
// length after the command and a status (ok, full, empty, bad index). A failed
// command leaves the buffer unchanged.
// Configuration (cfg_valid / cfg_ready): writes the capacity register, always
// ready; the usable capacity is the smaller of the register and DEPTH. Write
// it only while no command is in flight.
// Sequence: a command has a capture step for the command and the tail byte,
// then an execute step where every cell shifts at once. The result register
// is loaded at the end of execute; in_stall holds off the next command until
// then. A stalled result holds in the output register while the next command
// is captured; that command waits in execute until the result is taken.
// Reset: length zero, capacity 64, no result pending; cell contents are left
// as they are and never read before being written.
module indexed_char_deque_buffer_core #(
  parameter int DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [icdb_pkg::CMD_W-1:0]    in_cmd,
  input  logic [icdb_pkg::IDX_W-1:0]    in_char_index,
  input  logic [icdb_pkg::CHAR_W-1:0]   in_char_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [icdb_pkg::CHAR_W-1:0]   out_char_out,
  output logic [icdb_pkg::LEN_W-1:0]    out_length_now,
  output logic [icdb_pkg::ST_W-1:0]     out_status,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [icdb_pkg::LEN_W-1:0]    cfg_capacity
);

  icdb_pkg::ctl_t ctl;

  // configuration writes are always taken
  assign cfg_ready = 1'b1;

  icdb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl)
  );

  icdb_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .in_cmd         (in_cmd),
    .in_char_index  (in_char_index),
    .in_char_in     (in_char_in),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_capacity   (cfg_capacity),
    .out_char_out   (out_char_out),
    .out_length_now (out_length_now),
    .out_status     (out_status)
  );

endmodule

// ===== bench/indexed_char_deque_buffer_core_test.sv =====
// self-checking testbench for the indexed byte deque core
`timescale 1ns / 1ps

module indexed_char_deque_buffer_core_test;

  localparam int CMD_W  = icdb_pkg::CMD_W;
  localparam int IDX_W  = icdb_pkg::IDX_W;
  localparam int CHAR_W = icdb_pkg::CHAR_W;
  localparam int LEN_W  = icdb_pkg::LEN_W;
  localparam int ST_W   = icdb_pkg::ST_W;

  localparam int DEPTH = 64;
  localparam int QUIET_LIMIT = 2000;
  localparam int MAX_REPORTS = 10;
  localparam int PHASE_ITEMS = 75;

  // command codes the block ignores
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [IDX_W-1:0]  index;
    logic [CHAR_W-1:0] ch;
  } deque_cmd_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_out;
    logic [LEN_W-1:0]  length_now;
    logic [ST_W-1:0]   status;
  } deque_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CMD_W-1:0] in_cmd = '0;
  logic [IDX_W-1:0] in_char_index = '0;
  logic [CHAR_W-1:0] in_char_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [CHAR_W-1:0] out_char_out;
  logic [LEN_W-1:0] out_length_now;
  logic [ST_W-1:0] out_status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [LEN_W-1:0] cfg_capacity = '0;

  // commands waiting to be sent and results waiting to arrive
  deque_cmd_t cmd_backlog[$];
  deque_result_t expected_results[$];

  // predicted buffer contents and capacity register
  logic [CHAR_W-1:0] held_bytes[$];
  logic [LEN_W-1:0] capacity_now = icdb_pkg::CAP_RESET;

  int queued_count = 0;
  int accepted_count = 0;
  int fail_count = 0;
  int quiet_cycles = 0;
  bit idle_on = 1'b0;
  bit hold_sender = 1'b0;

  indexed_char_deque_buffer_core #(
    .DEPTH(DEPTH)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_cmd(in_cmd),
    .in_char_index(in_char_index),
    .in_char_in(in_char_in),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_char_out(out_char_out),
    .out_length_now(out_length_now),
    .out_status(out_status),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_capacity(cfg_capacity)
  );

  always #2 clk = ~clk;

  // apply one command to the predicted buffer and return its result
  function automatic deque_result_t predict_deque(input deque_cmd_t c);
    deque_result_t r;
    int len;
    int room;
    len = held_bytes.size();
    room = (capacity_now > DEPTH) ? DEPTH : capacity_now;
    r = '0;
    r.status = icdb_pkg::ST_OK;
    case (c.cmd)
      icdb_pkg::CMD_INSERT: begin
        // full is checked before the index
        if (len >= room) r.status = icdb_pkg::ST_FULL;
        else if (c.index > len) r.status = icdb_pkg::ST_INDEX;
        else held_bytes.insert(c.index, c.ch);
      end
      icdb_pkg::CMD_ERASE: begin
        if (c.index >= len) r.status = icdb_pkg::ST_INDEX;
        else held_bytes.delete(c.index);
      end
      icdb_pkg::CMD_PUSH_FRONT: begin
        if (len >= room) r.status = icdb_pkg::ST_FULL;
        else held_bytes.push_front(c.ch);
      end
      icdb_pkg::CMD_POP_FRONT: begin
        if (len == 0) r.status = icdb_pkg::ST_EMPTY;
        else r.char_out = held_bytes.pop_front();
      end
      icdb_pkg::CMD_PUSH_BACK: begin
        if (len >= room) r.status = icdb_pkg::ST_FULL;
        else held_bytes.push_back(c.ch);
      end
      icdb_pkg::CMD_POP_BACK: begin
        if (len == 0) r.status = icdb_pkg::ST_EMPTY;
        else r.char_out = held_bytes.pop_back();
      end
      default: ;
    endcase
    r.length_now = LEN_W'(held_bytes.size());
    return r;
  endfunction

  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("mismatch on %s: expected %0d, got %0d", field, want, got);
    end
  endtask

  task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] index,
                           input logic [CHAR_W-1:0] ch);
    deque_cmd_t c;
    c.cmd = cmd;
    c.index = index;
    c.ch = ch;
    cmd_backlog.push_back(c);
    queued_count++;
  endtask

  // wait until every queued command is sent and answered
  task automatic wait_drained();
    while (accepted_count != queued_count || expected_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_capacity(input logic [LEN_W-1:0] value);
    @(posedge clk);
    cfg_capacity <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    capacity_now = value;
  endtask

  // random command, biased toward growing or shrinking the buffer
  function automatic logic [CMD_W-1:0] pick_cmd(input int grow_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 4) return CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
    if ($urandom_range(0, 99) < grow_pct) begin
      case ($urandom_range(0, 2))
        0: return icdb_pkg::CMD_INSERT;
        1: return icdb_pkg::CMD_PUSH_FRONT;
        default: return icdb_pkg::CMD_PUSH_BACK;
      endcase
    end
    case ($urandom_range(0, 2))
      0: return icdb_pkg::CMD_ERASE;
      1: return icdb_pkg::CMD_POP_FRONT;
      default: return icdb_pkg::CMD_POP_BACK;
    endcase
  endfunction

  // command driver
  always @(posedge clk) begin : drive_commands
    deque_cmd_t cur_cmd;
    bit presenting;
    int send_gap;
    if (!rst_n) begin
      presenting = 1'b0;
      send_gap = 0;
      in_valid <= 1'b0;
    end else begin
      // transfer accepted: predict its result
      if (presenting && !in_stall) begin
        expected_results.push_back(predict_deque(cur_cmd));
        accepted_count++;
        presenting = 1'b0;
        send_gap = idle_on ? $urandom_range(0, 15) : 0;
      end
      if (!presenting) begin
        if (send_gap > 0) send_gap--;
        else if (!hold_sender && cmd_backlog.size() > 0) begin
          cur_cmd = cmd_backlog.pop_front();
          presenting = 1'b1;
        end
      end
      in_valid <= presenting;
      in_cmd <= cur_cmd.cmd;
      in_char_index <= cur_cmd.index;
      in_char_in <= cur_cmd.ch;
    end
  end

  // result monitor and receiver stall
  always @(posedge clk) begin : check_results
    deque_result_t want;
    int recv_hold;
    if (!rst_n) begin
      recv_hold = 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("unexpected result: char %0d length %0d status %0d",
                     out_char_out, out_length_now, out_status);
        end else begin
          want = expected_results.pop_front();
          check_field("char_out", want.char_out, out_char_out);
          check_field("length_now", want.length_now, out_length_now);
          check_field("status", want.status, out_status);
        end
        recv_hold = idle_on ? $urandom_range(0, 15) : 0;
      end else if (out_valid && recv_hold > 0) begin
        recv_hold--;
      end
      out_stall <= (recv_hold != 0);
    end
  end

  // end the run when nothing moves for too long
  always @(posedge clk) begin : watchdog
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // stimulus
  initial begin : run_stimulus
    logic [LEN_W-1:0] caps[8];
    int grow[8];
    int len_est;
    logic [CMD_W-1:0] cmd;
    logic [IDX_W-1:0] index;

    caps = '{7'd127, 7'd1, 7'd0, 7'd64, 7'd2, 7'd37, 7'd100, 7'd63};
    grow = '{80, 25, 50, 60, 50, 55, 70, 40};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty buffer errors, then fill at ends, middle and tail
    idle_on = 1'b1;
    queue_cmd(icdb_pkg::CMD_POP_FRONT, 6'd0, 8'h11);
    queue_cmd(icdb_pkg::CMD_POP_BACK, 6'd63, 8'hEE);
    queue_cmd(icdb_pkg::CMD_ERASE, 6'd0, 8'h00);
    queue_cmd(icdb_pkg::CMD_INSERT, 6'd1, 8'h3C);
    queue_cmd(icdb_pkg::CMD_INSERT, 6'd0, 8'hFF);
    queue_cmd(icdb_pkg::CMD_PUSH_FRONT, 6'd0, 8'h00);
    queue_cmd(icdb_pkg::CMD_PUSH_BACK, 6'd0, 8'hA5);
    queue_cmd(icdb_pkg::CMD_INSERT, 6'd3, 8'h5A);
    queue_cmd(icdb_pkg::CMD_INSERT, 6'd63, 8'h77);
    queue_cmd(icdb_pkg::CMD_INSERT, 6'd2, 8'h81);
    queue_cmd(icdb_pkg::CMD_ERASE, 6'd63, 8'hFF);
    queue_cmd(icdb_pkg::CMD_ERASE, 6'd1, 8'h00);
    queue_cmd(CMD_SPARE_LO, 6'd63, 8'hFF);
    queue_cmd(CMD_SPARE_HI, 6'd0, 8'h00);
    queue_cmd(icdb_pkg::CMD_POP_FRONT, 6'd0, 8'h00);
    queue_cmd(icdb_pkg::CMD_POP_BACK, 6'd0, 8'h00);
    wait_drained();

    // small capacity: full, and full takes precedence over a bad index
    write_capacity(7'd3);
    queue_cmd(icdb_pkg::CMD_PUSH_BACK, 6'd0, 8'h7E);
    queue_cmd(icdb_pkg::CMD_PUSH_FRONT, 6'd0, 8'h01);
    queue_cmd(icdb_pkg::CMD_INSERT, 6'd63, 8'h02);
    wait_drained();

    // zero capacity below the length: adds fail, removals work
    write_capacity(7'd0);
    queue_cmd(icdb_pkg::CMD_PUSH_BACK, 6'd0, 8'h10);
    queue_cmd(icdb_pkg::CMD_INSERT, 6'd0, 8'h20);
    queue_cmd(icdb_pkg::CMD_ERASE, 6'd2, 8'h00);
    queue_cmd(icdb_pkg::CMD_POP_FRONT, 6'd0, 8'h00);
    queue_cmd(icdb_pkg::CMD_POP_BACK, 6'd0, 8'h00);
    queue_cmd(icdb_pkg::CMD_POP_BACK, 6'd0, 8'h00);
    wait_drained();

    // random phases over several capacity settings
    for (int p = 0; p < 8; p++) begin
      write_capacity(caps[p]);
      idle_on = (p % 3) != 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        while (cmd_backlog.size() >= 2) @(posedge clk);
        // sender holds off until everything is answered
        if (n == PHASE_ITEMS / 2 && p % 2 == 1) begin
          hold_sender = 1'b1;
          while (expected_results.size() != 0 || in_valid) @(posedge clk);
          hold_sender = 1'b0;
        end
        len_est = held_bytes.size();
        cmd = pick_cmd(grow[p]);
        if ($urandom_range(0, 99) < 15)
          index = IDX_W'($urandom_range(0, 63));
        else
          index = IDX_W'($urandom_range(0, (len_est > 63) ? 63 : len_est));
        queue_cmd(cmd, index, CHAR_W'($urandom_range(0, 255)));
      end
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
